// ===== rtl/core/pft_pkg.sv =====
package pft_pkg;

    localparam int COORD_W    = 32;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int INDEX_IN_W = 5;
    localparam int HOLD_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ALU_W      = 64;

    typedef enum logic [1:0] {
        OP_UPD_POS  = 2'd0,
        OP_UPD_GOAL = 2'd1,
        OP_SNAP     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_POS  = 2'd0,
        KIND_GOAL = 2'd1,
        KIND_SUM  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_TIMEOUT  = 2'd0,
        CFG_GOAL_TIMEOUT = 2'd1,
        CFG_HOLD_RADIUS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_CMP,
        ST_S1_SCAN,
        ST_S1_PAGE,
        ST_S1_PCMP,
        ST_S1_GAGE,
        ST_S1_GCMP,
        ST_S1_EMIT,
        ST_S2_SCAN,
        ST_S2_DX,
        ST_S2_AX,
        ST_S2_DY,
        ST_S2_AY,
        ST_S2_CX,
        ST_S2_CY,
        ST_S2_MX,
        ST_S2_MY,
        ST_S2_SUM,
        ST_S2_RR,
        ST_S2_CMP,
        ST_S2_EMIT,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic we_pos;
        logic we_goal;
    } t_wr_ctl;

    typedef struct packed {
        t_point            pos;
        t_point            goal;
        logic [TIME_W-1:0] pos_tm;
        logic [TIME_W-1:0] goal_tm;
        logic              pos_vld;
        logic              goal_vld;
    } t_rd_data;

    typedef struct packed {
        logic [COUNT_W-1:0] mp;
        logic [COUNT_W-1:0] sp;
        logic [COUNT_W-1:0] fp;
        logic [COUNT_W-1:0] mg;
        logic [COUNT_W-1:0] sg;
        logic [COUNT_W-1:0] fg;
        logic [COUNT_W-1:0] ag;
    } t_counts;

    function automatic logic [ALU_W-1:0] sext64(input logic [COORD_W-1:0] v);
        return {{(ALU_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] zext64(input logic [TIME_W-1:0] v);
        return {{(ALU_W-TIME_W){1'b0}}, v};
    endfunction

endpackage

// ===== rtl/core/peer_freshness_table.sv =====
// peer position and goal table with timed snapshots
// input channel: i_valid / o_stall carries one operation per beat: a position
// update, a goal update or a snapshot at time i_time_stamp. o_stall is high
// whenever the sequencer is busy, so one operation is worked on at a time.
// an update steps through accept, table read, then stamp compare and write;
// out-of-range updates and unknown operations are dropped at accept.
// a snapshot runs two passes over the table through one shared add/sub/mul
// unit: pass one ages each peer's position and goal against the timeouts and
// emits a beat per fresh position; pass two skips each peer that is not fresh
// on both sides and works each candidate through abs deltas, radius compares,
// three squares and a sum. a snapshot ends with a summary beat that carries
// the counts and o_last_item.
// output channel: o_valid / i_stall, one result register; while i_stall holds
// a beat, the sequencer waits at the next emit and the beat stays unchanged.
// reset (i_rst_n low, synchronous) clears the presence flags, the pending
// output and loads the config defaults; no clearing pass is needed.
// config writes (i_cfg_we) take effect at once and belong to idle time.
module peer_freshness_table #(
    parameter int NUM_PEERS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [pft_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pft_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_operation,
    input  logic [pft_pkg::INDEX_IN_W-1:0]          i_peer_index,
    input  logic signed [pft_pkg::COORD_W-1:0]      i_coord_x,
    input  logic signed [pft_pkg::COORD_W-1:0]      i_coord_y,
    input  logic signed [pft_pkg::COORD_W-1:0]      i_coord_z,
    input  logic [pft_pkg::TIME_W-1:0]              i_time_stamp,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [1:0]                              o_item_kind,
    output logic signed [pft_pkg::COORD_W-1:0]      o_out_x,
    output logic signed [pft_pkg::COORD_W-1:0]      o_out_y,
    output logic signed [pft_pkg::COORD_W-1:0]      o_out_z,
    output logic [pft_pkg::COUNT_W-1:0]             o_pos_missing,
    output logic [pft_pkg::COUNT_W-1:0]             o_pos_stale,
    output logic [pft_pkg::COUNT_W-1:0]             o_pos_fresh,
    output logic [pft_pkg::COUNT_W-1:0]             o_goal_missing,
    output logic [pft_pkg::COUNT_W-1:0]             o_goal_stale,
    output logic [pft_pkg::COUNT_W-1:0]             o_goal_fresh,
    output logic [pft_pkg::COUNT_W-1:0]             o_goal_active,
    output logic                                    o_last_item
);
    import pft_pkg::*;

    localparam int IDX_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int CNT_W = $clog2(NUM_PEERS + 1);
    localparam int SUM_W = COUNT_W + 2;

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_counts            r_cnt, n_cnt;
    logic               r_o_valid, n_o_valid;
    logic [TIME_W-1:0]  r_pos_to;
    logic [TIME_W-1:0]  r_goal_to;
    logic [HOLD_W-1:0]  r_hold;

    // datapath
    logic [NUM_PEERS-1:0] r_pf, n_pf;
    logic [NUM_PEERS-1:0] r_gf, n_gf;
    logic               r_is_goal, n_is_goal;
    logic [TIME_W-1:0]  r_stamp, n_stamp;
    t_point             r_pt, n_pt;
    logic [TIME_W:0]    r_age, n_age;
    logic [COORD_W:0]   r_ax, n_ax;
    logic [COORD_W:0]   r_ay, n_ay;
    logic [ALU_W-1:0]   r_acc, n_acc;
    logic [ALU_W-1:0]   r_tmp, n_tmp;
    t_kind              r_o_kind, n_o_kind;
    t_point             r_o_pt, n_o_pt;
    t_counts            r_o_cnt, n_o_cnt;
    logic               r_o_last, n_o_last;

    t_alu_req           alu_req;
    logic [ALU_W:0]     alu_res;
    t_wr_ctl            wr_ctl;
    t_rd_data           rd;
    logic [IDX_W-1:0]   cur;
    logic               out_free;
    logic               fresh;
    logic               older;

    assign cur      = r_idx[IDX_W-1:0];
    assign out_free = !r_o_valid || !i_stall;

    pft_store #(
        .NUM_PEERS (NUM_PEERS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cur),
        .i_wr_addr (cur),
        .i_wr      (wr_ctl),
        .i_wr_pt   (r_pt),
        .i_wr_tm   (r_stamp),
        .o_rd      (rd)
    );

    pft_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pf      = r_pf;
        n_gf      = r_gf;
        n_is_goal = r_is_goal;
        n_stamp   = r_stamp;
        n_pt      = r_pt;
        n_age     = r_age;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_acc     = r_acc;
        n_tmp     = r_tmp;
        n_o_valid = r_o_valid && i_stall;
        n_o_kind  = r_o_kind;
        n_o_pt    = r_o_pt;
        n_o_cnt   = r_o_cnt;
        n_o_last  = r_o_last;
        alu_req   = '{op: ALU_SUB, a: '0, b: '0};
        wr_ctl    = '0;
        fresh     = 1'b0;
        older     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_stamp   = i_time_stamp;
                    n_pt      = '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
                    n_is_goal = (i_operation == OP_UPD_GOAL);
                    case (i_operation)
                        OP_UPD_POS, OP_UPD_GOAL: begin
                            if (i_peer_index < INDEX_IN_W'(NUM_PEERS)) begin
                                n_idx   = CNT_W'(i_peer_index);
                                n_state = ST_UPD_RD;
                            end
                        end
                        OP_SNAP: begin
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_state = ST_S1_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPD_RD: begin
                n_state = ST_UPD_CMP;
            end
            ST_UPD_CMP: begin
                // equal stamps overwrite, only a strictly older one is dropped
                alu_req = '{op: ALU_SUB, a: zext64(r_stamp),
                            b: zext64(r_is_goal ? rd.goal_tm : rd.pos_tm)};
                older = alu_res[ALU_W];
                if (r_is_goal) begin
                    wr_ctl.we_goal = !(rd.goal_vld && older);
                end else begin
                    wr_ctl.we_pos = !(rd.pos_vld && older);
                end
                n_state = ST_IDLE;
            end
            ST_S1_SCAN: begin
                if (r_idx == CNT_W'(NUM_PEERS)) begin
                    n_idx   = '0;
                    n_state = ST_S2_SCAN;
                end else begin
                    n_state = ST_S1_PAGE;
                end
            end
            ST_S1_PAGE: begin
                alu_req = '{op: ALU_SUB, a: zext64(r_stamp), b: zext64(rd.pos_tm)};
                n_age   = alu_res[TIME_W:0];
                n_state = ST_S1_PCMP;
            end
            ST_S1_PCMP: begin
                // negative age is fresh
                alu_req = '{op: ALU_SUB, a: zext64(r_pos_to), b: zext64(r_age[TIME_W-1:0])};
                fresh   = r_age[TIME_W] || !alu_res[ALU_W];
                n_pf[cur] = rd.pos_vld && fresh;
                if (!rd.pos_vld) begin
                    n_cnt.mp = r_cnt.mp + COUNT_W'(1);
                end else if (!fresh) begin
                    n_cnt.sp = r_cnt.sp + COUNT_W'(1);
                end else begin
                    n_cnt.fp = r_cnt.fp + COUNT_W'(1);
                end
                n_state = ST_S1_GAGE;
            end
            ST_S1_GAGE: begin
                alu_req = '{op: ALU_SUB, a: zext64(r_stamp), b: zext64(rd.goal_tm)};
                n_age   = alu_res[TIME_W:0];
                n_state = ST_S1_GCMP;
            end
            ST_S1_GCMP: begin
                alu_req = '{op: ALU_SUB, a: zext64(r_goal_to), b: zext64(r_age[TIME_W-1:0])};
                fresh   = r_age[TIME_W] || !alu_res[ALU_W];
                n_gf[cur] = rd.goal_vld && fresh;
                if (!rd.goal_vld) begin
                    n_cnt.mg = r_cnt.mg + COUNT_W'(1);
                end else if (!fresh) begin
                    n_cnt.sg = r_cnt.sg + COUNT_W'(1);
                end else begin
                    n_cnt.fg = r_cnt.fg + COUNT_W'(1);
                end
                if (r_pf[cur]) begin
                    n_state = ST_S1_EMIT;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_S1_SCAN;
                end
            end
            ST_S1_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_POS;
                    n_o_pt    = rd.pos;
                    n_o_cnt   = '0;
                    n_o_last  = 1'b0;
                    n_idx     = r_idx + CNT_W'(1);
                    n_state   = ST_S1_SCAN;
                end
            end
            ST_S2_SCAN: begin
                if (r_idx == CNT_W'(NUM_PEERS)) begin
                    n_state = ST_SUMMARY;
                end else if (r_pf[cur] && r_gf[cur]) begin
                    n_state = ST_S2_DX;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_S2_DX: begin
                alu_req = '{op: ALU_SUB, a: sext64(rd.goal.x), b: sext64(rd.pos.x)};
                n_ax    = alu_res[COORD_W:0];
                n_state = ST_S2_AX;
            end
            ST_S2_AX: begin
                alu_req = '{op: ALU_SUB, a: '0,
                            b: {{(ALU_W-COORD_W-1){r_ax[COORD_W]}}, r_ax}};
                if (r_ax[COORD_W]) begin
                    n_ax = alu_res[COORD_W:0];
                end
                n_state = ST_S2_DY;
            end
            ST_S2_DY: begin
                alu_req = '{op: ALU_SUB, a: sext64(rd.goal.y), b: sext64(rd.pos.y)};
                n_ay    = alu_res[COORD_W:0];
                n_state = ST_S2_AY;
            end
            ST_S2_AY: begin
                alu_req = '{op: ALU_SUB, a: '0,
                            b: {{(ALU_W-COORD_W-1){r_ay[COORD_W]}}, r_ay}};
                if (r_ay[COORD_W]) begin
                    n_ay = alu_res[COORD_W:0];
                end
                n_state = ST_S2_CX;
            end
            ST_S2_CX: begin
                // a delta beyond the radius on one axis settles it
                alu_req = '{op: ALU_SUB, a: {{(ALU_W-HOLD_W){1'b0}}, r_hold},
                            b: {{(ALU_W-COORD_W-1){1'b0}}, r_ax}};
                n_state = alu_res[ALU_W] ? ST_S2_EMIT : ST_S2_CY;
            end
            ST_S2_CY: begin
                alu_req = '{op: ALU_SUB, a: {{(ALU_W-HOLD_W){1'b0}}, r_hold},
                            b: {{(ALU_W-COORD_W-1){1'b0}}, r_ay}};
                n_state = alu_res[ALU_W] ? ST_S2_EMIT : ST_S2_MX;
            end
            ST_S2_MX: begin
                // both deltas now fit the radius width
                alu_req = '{op: ALU_MUL, a: {{(ALU_W-COORD_W-1){1'b0}}, r_ax},
                            b: {{(ALU_W-COORD_W-1){1'b0}}, r_ax}};
                n_acc   = alu_res[ALU_W-1:0];
                n_state = ST_S2_MY;
            end
            ST_S2_MY: begin
                alu_req = '{op: ALU_MUL, a: {{(ALU_W-COORD_W-1){1'b0}}, r_ay},
                            b: {{(ALU_W-COORD_W-1){1'b0}}, r_ay}};
                n_tmp   = alu_res[ALU_W-1:0];
                n_state = ST_S2_SUM;
            end
            ST_S2_SUM: begin
                alu_req = '{op: ALU_ADD, a: r_acc, b: r_tmp};
                n_acc   = alu_res[ALU_W-1:0];
                n_state = ST_S2_RR;
            end
            ST_S2_RR: begin
                alu_req = '{op: ALU_MUL, a: {{(ALU_W-HOLD_W){1'b0}}, r_hold},
                            b: {{(ALU_W-HOLD_W){1'b0}}, r_hold}};
                n_tmp   = alu_res[ALU_W-1:0];
                n_state = ST_S2_CMP;
            end
            ST_S2_CMP: begin
                // r^2 < dx^2 + dy^2 means beyond hold
                alu_req = '{op: ALU_SUB, a: r_tmp, b: r_acc};
                if (alu_res[ALU_W]) begin
                    n_state = ST_S2_EMIT;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_S2_SCAN;
                end
            end
            ST_S2_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_GOAL;
                    n_o_pt    = rd.goal;
                    n_o_cnt   = '0;
                    n_o_last  = 1'b0;
                    n_cnt.ag  = r_cnt.ag + COUNT_W'(1);
                    n_idx     = r_idx + CNT_W'(1);
                    n_state   = ST_S2_SCAN;
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_SUM;
                    n_o_pt    = '0;
                    n_o_cnt   = r_cnt;
                    n_o_last  = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_to  <= TIME_W'(1000);
            r_goal_to <= TIME_W'(1000);
            r_hold    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POS_TIMEOUT:  r_pos_to  <= i_cfg_data[TIME_W-1:0];
                CFG_GOAL_TIMEOUT: r_goal_to <= i_cfg_data[TIME_W-1:0];
                CFG_HOLD_RADIUS:  r_hold    <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pf      <= n_pf;
        r_gf      <= n_gf;
        r_is_goal <= n_is_goal;
        r_stamp   <= n_stamp;
        r_pt      <= n_pt;
        r_age     <= n_age;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_acc     <= n_acc;
        r_tmp     <= n_tmp;
        r_o_kind  <= n_o_kind;
        r_o_pt    <= n_o_pt;
        r_o_cnt   <= n_o_cnt;
        r_o_last  <= n_o_last;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_item_kind    = r_o_kind;
    assign o_out_x        = r_o_pt.x;
    assign o_out_y        = r_o_pt.y;
    assign o_out_z        = r_o_pt.z;
    assign o_pos_missing  = r_o_cnt.mp;
    assign o_pos_stale    = r_o_cnt.sp;
    assign o_pos_fresh    = r_o_cnt.fp;
    assign o_goal_missing = r_o_cnt.mg;
    assign o_goal_stale   = r_o_cnt.sg;
    assign o_goal_fresh   = r_o_cnt.fg;
    assign o_goal_active  = r_o_cnt.ag;
    assign o_last_item    = r_o_last;

    // a snapshot always keeps the block busy on the following cycle
    a_snap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation == OP_SNAP) |=> o_stall)
        else $error("snapshot accepted but block not busy");

    // the last beat of a run is always the summary with zero coordinates
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_kind == KIND_SUM && r_o_pt == '0))
        else $error("last beat is not a summary");

    // position classes never cover more peers than the table holds
    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_cnt.mp) + SUM_W'(r_cnt.sp) + SUM_W'(r_cnt.fp)) <= SUM_W'(NUM_PEERS))
        else $error("position counts exceed table size");

endmodule

// ===== rtl/core/pft_alu.sv =====
module pft_alu (
    input  pft_pkg::t_alu_req         i_req,
    output logic [pft_pkg::ALU_W:0]   o_res
);
    import pft_pkg::*;

    logic [2*HOLD_W-1:0] prod;

    // bit ALU_W of a subtraction is the borrow, i.e. a < b unsigned
    always_comb begin
        prod = i_req.a[HOLD_W-1:0] * i_req.b[HOLD_W-1:0];
        case (i_req.op)
            ALU_ADD: o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
            ALU_MUL: o_res = {{(ALU_W+1-2*HOLD_W){1'b0}}, prod};
            default: o_res = '0;
        endcase
    end

endmodule

// ===== rtl/core/pft_store.sv =====
module pft_store #(
    parameter int NUM_PEERS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [((NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1)-1:0] i_rd_addr,
    input  logic [((NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1)-1:0] i_wr_addr,
    input  pft_pkg::t_wr_ctl                           i_wr,
    input  pft_pkg::t_point                            i_wr_pt,
    input  logic [pft_pkg::TIME_W-1:0]                 i_wr_tm,
    output pft_pkg::t_rd_data                          o_rd
);
    import pft_pkg::*;

    t_point            r_pos_mem  [NUM_PEERS];
    t_point            r_goal_mem [NUM_PEERS];
    logic [TIME_W-1:0] r_pos_tm   [NUM_PEERS];
    logic [TIME_W-1:0] r_goal_tm  [NUM_PEERS];
    logic [NUM_PEERS-1:0] r_pos_vld;
    logic [NUM_PEERS-1:0] r_goal_vld;
    t_rd_data          r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_pos) begin
            r_pos_mem[i_wr_addr] <= i_wr_pt;
            r_pos_tm[i_wr_addr]  <= i_wr_tm;
        end
        if (i_wr.we_goal) begin
            r_goal_mem[i_wr_addr] <= i_wr_pt;
            r_goal_tm[i_wr_addr]  <= i_wr_tm;
        end
        r_rd.pos      <= r_pos_mem[i_rd_addr];
        r_rd.goal     <= r_goal_mem[i_rd_addr];
        r_rd.pos_tm   <= r_pos_tm[i_rd_addr];
        r_rd.goal_tm  <= r_goal_tm[i_rd_addr];
        r_rd.pos_vld  <= r_pos_vld[i_rd_addr];
        r_rd.goal_vld <= r_goal_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld  <= '0;
            r_goal_vld <= '0;
        end else begin
            if (i_wr.we_pos) begin
                r_pos_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr.we_goal) begin
                r_goal_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== bench/tb_peer_freshness_table.sv =====
module tb_peer_freshness_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pft_pkg::*;

    localparam int NUM_PEERS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 76;

    typedef struct {
        t_kind   kind;
        t_point  pt;
        t_counts cnt;
        logic    last;
    } t_beat;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_operation;
    logic [INDEX_IN_W-1:0]    i_peer_index;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic signed [COORD_W-1:0] i_coord_z;
    logic [TIME_W-1:0]        i_time_stamp;
    logic                     o_valid;
    logic                     i_stall;
    logic [1:0]               o_item_kind;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic [COUNT_W-1:0]       o_pos_missing;
    logic [COUNT_W-1:0]       o_pos_stale;
    logic [COUNT_W-1:0]       o_pos_fresh;
    logic [COUNT_W-1:0]       o_goal_missing;
    logic [COUNT_W-1:0]       o_goal_stale;
    logic [COUNT_W-1:0]       o_goal_fresh;
    logic [COUNT_W-1:0]       o_goal_active;
    logic                     o_last_item;

    // shadow copy of the peer table and its registers
    t_point      pos_tab  [NUM_PEERS];
    t_point      goal_tab [NUM_PEERS];
    logic [31:0] pos_tm   [NUM_PEERS];
    logic [31:0] goal_tm  [NUM_PEERS];
    bit          pos_seen [NUM_PEERS];
    bit          goal_seen[NUM_PEERS];
    logic [31:0] pos_timeout_r;
    logic [31:0] goal_timeout_r;
    logic [30:0] hold_radius_r;

    t_beat       pending_beats[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    logic [31:0] now_ms;

    peer_freshness_table #(
        .NUM_PEERS(NUM_PEERS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_peer_index   (i_peer_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_time_stamp   (i_time_stamp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_item_kind    (o_item_kind),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_pos_missing  (o_pos_missing),
        .o_pos_stale    (o_pos_stale),
        .o_pos_fresh    (o_pos_fresh),
        .o_goal_missing (o_goal_missing),
        .o_goal_stale   (o_goal_stale),
        .o_goal_fresh   (o_goal_fresh),
        .o_goal_active  (o_goal_active),
        .o_last_item    (o_last_item)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_point mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        return '{x: x, y: y, z: z};
    endfunction

    // negative age counts as fresh
    function automatic bit is_recent(bit present, logic [31:0] stamp, logic [31:0] now,
                                     logic [31:0] limit);
        logic signed [33:0] age;
        if (!present)
            return 1'b0;
        age = $signed({2'b00, now}) - $signed({2'b00, stamp});
        return age <= $signed({2'b00, limit});
    endfunction

    function automatic bit goal_beyond_hold(t_point g, t_point p, logic [30:0] radius);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic [65:0]        dist_sq;
        logic [65:0]        rad_sq;
        dx = $signed({g.x[31], g.x}) - $signed({p.x[31], p.x});
        dy = $signed({g.y[31], g.y}) - $signed({p.y[31], p.y});
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        dist_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        rad_sq = 66'(radius) * 66'(radius);
        return dist_sq > rad_sq;
    endfunction

    function automatic t_beat point_beat(t_kind kind, t_point pt);
        return '{kind: kind, pt: pt, cnt: '0, last: 1'b0};
    endfunction

    task automatic queue_beat(t_beat beat);
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    // updates the shadow table, or queues the beats of a snapshot
    task automatic apply_peer_op(logic [1:0] op, logic [4:0] idx, t_point pt,
                                 logic [31:0] stamp);
        t_counts cnt;
        bit      pf;
        bit      gf;
        int      mp, sp, fp, mg, sg, fg, ag;
        if (op == OP_UPD_POS || op == OP_UPD_GOAL) begin
            if (idx >= NUM_PEERS)
                return;
            if (op == OP_UPD_POS) begin
                if (!(pos_seen[idx] && stamp < pos_tm[idx])) begin
                    pos_tab[idx] = pt;
                    pos_tm[idx] = stamp;
                    pos_seen[idx] = 1'b1;
                end
            end else begin
                if (!(goal_seen[idx] && stamp < goal_tm[idx])) begin
                    goal_tab[idx] = pt;
                    goal_tm[idx] = stamp;
                    goal_seen[idx] = 1'b1;
                end
            end
            return;
        end
        if (op != OP_SNAP)
            return;
        mp = 0; sp = 0; fp = 0; mg = 0; sg = 0; fg = 0; ag = 0;
        for (int i = 0; i < NUM_PEERS; i++) begin
            pf = is_recent(pos_seen[i], pos_tm[i], stamp, pos_timeout_r);
            gf = is_recent(goal_seen[i], goal_tm[i], stamp, goal_timeout_r);
            if (!pos_seen[i]) begin
                mp++;
            end else if (!pf) begin
                sp++;
            end else begin
                fp++;
                queue_beat(point_beat(KIND_POS, pos_tab[i]));
            end
            if (!goal_seen[i])
                mg++;
            else if (!gf)
                sg++;
            else
                fg++;
        end
        for (int i = 0; i < NUM_PEERS; i++) begin
            pf = is_recent(pos_seen[i], pos_tm[i], stamp, pos_timeout_r);
            gf = is_recent(goal_seen[i], goal_tm[i], stamp, goal_timeout_r);
            if (pf && gf && goal_beyond_hold(goal_tab[i], pos_tab[i], hold_radius_r)) begin
                ag++;
                queue_beat(point_beat(KIND_GOAL, goal_tab[i]));
            end
        end
        cnt.mp = mp[4:0];
        cnt.sp = sp[4:0];
        cnt.fp = fp[4:0];
        cnt.mg = mg[4:0];
        cnt.sg = sg[4:0];
        cnt.fg = fg[4:0];
        cnt.ag = ag[4:0];
        queue_beat('{kind: KIND_SUM, pt: '0, cnt: cnt, last: 1'b1});
    endtask

    // sender works in bursts; valid stays high across back-to-back beats
    task automatic send_op(logic [1:0] op, logic [4:0] idx, t_point pt, logic [31:0] stamp);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        i_operation = op;
        i_peer_index = idx;
        i_coord_x = pt.x;
        i_coord_y = pt.y;
        i_coord_z = pt.z;
        i_time_stamp = stamp;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_peer_op(op, idx, pt, stamp);
        burst_left--;
    endtask

    task automatic wait_drained(int settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx sel, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (sel)
            CFG_POS_TIMEOUT:  pos_timeout_r = value;
            CFG_GOAL_TIMEOUT: goal_timeout_r = value;
            CFG_HOLD_RADIUS:  hold_radius_r = value[30:0];
            default: ;
        endcase
    endtask

    // updates can still be in flight after the last summary beat
    task automatic write_config(logic [31:0] pos_to, logic [31:0] goal_to, logic [30:0] rad);
        wait_drained(SETTLE_CYCLES);
        write_reg(CFG_POS_TIMEOUT, pos_to);
        write_reg(CFG_GOAL_TIMEOUT, goal_to);
        write_reg(CFG_HOLD_RADIUS, {1'b0, rad});
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            4:       return 32'd1000;
            5:       return $urandom;
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    task automatic test_empty_table();
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd0);
        send_op(OP_UPD_POS, 5'd31, mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF),
                32'hFFFF_FFFF);
        send_op(OP_UPD_GOAL, 5'd16, mk_point(1, 2, 3), 32'd0);
        send_op(OP_UNUSED, 5'd3, mk_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                32'd7);
        send_op(OP_SNAP, 5'd31, mk_point(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF), 32'd0);
    endtask

    task automatic test_stamp_order();
        send_op(OP_UPD_POS, 5'd0, mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
                32'd100);
        send_op(OP_UPD_GOAL, 5'd0, mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                32'd100);
        // older stamp dropped, equal stamp overwrites
        send_op(OP_UPD_POS, 5'd0, mk_point(1, 2, 3), 32'd99);
        send_op(OP_UPD_GOAL, 5'd0, mk_point(32'h0001_0000, 0, 32'hFFFF_FFFF), 32'd100);
        send_op(OP_UPD_POS, 5'd15, mk_point(0, 0, 0), 32'd5000);
        send_op(OP_UPD_GOAL, 5'd15, mk_point(0, 0, 32'h7FFF_FFFF), 32'd5000);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd1100);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd1101);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'hFFFF_FFFF);
    endtask

    task automatic test_timeouts_and_hold();
        write_config(32'd0, 32'd0, 31'd0);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd5000);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd100);
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'hFFFF_FFFF);
        write_config(32'd1000, 32'd1000, 31'd5);
        // 3-4-5 triangle lands exactly on the radius
        send_op(OP_UPD_POS, 5'd3, mk_point(0, 0, 0), 32'd200);
        send_op(OP_UPD_GOAL, 5'd3, mk_point(3, 4, 9), 32'd200);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd300);
        send_op(OP_UPD_GOAL, 5'd3, mk_point(-6, 0, 0), 32'd250);
        send_op(OP_SNAP, 5'd0, mk_point(0, 0, 0), 32'd300);
    endtask

    task automatic test_random_traffic();
        t_point      pt;
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [31:0] stamp;
        logic [31:0] limit;
        logic [31:0] span;
        logic [31:0] rspan;
        logic [30:0] rad;
        int          pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       rad = 31'd0;
                1:       rad = 31'h7FFF_FFFF;
                2:       rad = 31'($urandom);
                default: rad = 31'($urandom_range(0, 32'h0002_0000));
            endcase
            write_config(pick_timeout(), pick_timeout(), rad);
            if (phase == 0)
                now_ms = 32'd0;
            else if (phase == PHASES - 1)
                now_ms = 32'hFFFF_F000;
            else
                now_ms = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 3)
                    wait_drained(0);
                now_ms += $urandom_range(0, 120);
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    op = OP_UNUSED;
                else if (pick < 38)
                    op = OP_UPD_POS;
                else if (pick < 70)
                    op = OP_UPD_GOAL;
                else
                    op = OP_SNAP;
                if ($urandom_range(0, 99) < 12)
                    idx = 5'($urandom_range(NUM_PEERS, 31));
                else
                    idx = 5'($urandom_range(0, NUM_PEERS - 1));
                pt.x = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
                pt.y = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
                pt.z = $urandom;
                stamp = now_ms;
                if (op == OP_UPD_POS || op == OP_UPD_GOAL) begin
                    limit = (op == OP_UPD_POS) ? pos_timeout_r : goal_timeout_r;
                    span = (limit > 3000) ? 32'd3000 : limit + limit / 2 + 2;
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        stamp = $urandom;
                    else if (pick < 3)
                        stamp = now_ms + $urandom_range(1, 500);
                    else
                        stamp = now_ms - $urandom_range(0, span);
                end
                // goals near the peer's own position so the hold test matters
                if (op == OP_UPD_GOAL && idx < NUM_PEERS && pos_seen[idx] &&
                    $urandom_range(0, 99) < 65) begin
                    rspan = (hold_radius_r > 31'h2000_0000) ? 32'h4000_0000
                                                            : hold_radius_r + hold_radius_r / 4 + 2;
                    pt.x = pos_tab[idx].x + ($urandom_range(0, 2 * rspan) - rspan);
                    pt.y = pos_tab[idx].y + ($urandom_range(0, 2 * rspan) - rspan);
                end
                if (op == OP_SNAP && $urandom_range(0, 9) == 0)
                    stamp = $urandom;
                send_op(op, idx, pt, stamp);
            end
        end
    endtask

    // receiver stall pattern, switching between quiet and busy stretches
    initial begin
        int mode;
        int run;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(30, 200);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall = 1'b0;
                    1:       i_stall = $urandom_range(0, 1);
                    2:       i_stall = ($urandom_range(0, 3) != 0);
                    default: i_stall = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: item_kind %0d", o_item_kind);
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("item_kind", 32'(want.kind), 32'(o_item_kind));
                check_field("out_x", 32'(want.pt.x), 32'(o_out_x));
                check_field("out_y", 32'(want.pt.y), 32'(o_out_y));
                check_field("out_z", 32'(want.pt.z), 32'(o_out_z));
                check_field("pos_missing", 32'(want.cnt.mp), 32'(o_pos_missing));
                check_field("pos_stale", 32'(want.cnt.sp), 32'(o_pos_stale));
                check_field("pos_fresh", 32'(want.cnt.fp), 32'(o_pos_fresh));
                check_field("goal_missing", 32'(want.cnt.mg), 32'(o_goal_missing));
                check_field("goal_stale", 32'(want.cnt.sg), 32'(o_goal_stale));
                check_field("goal_fresh", 32'(want.cnt.fg), 32'(o_goal_fresh));
                check_field("goal_active", 32'(want.cnt.ag), 32'(o_goal_active));
                check_field("last_item", 32'(want.last), 32'(o_last_item));
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_peer_freshness_table: done, errors");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_POS_TIMEOUT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_operation = OP_UPD_POS;
        i_peer_index = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_time_stamp = '0;
        pos_timeout_r = 32'd1000;
        goal_timeout_r = 32'd1000;
        hold_radius_r = 31'd0;
        foreach (pos_seen[i]) begin
            pos_seen[i] = 1'b0;
            goal_seen[i] = 1'b0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_table();
        test_stamp_order();
        test_timeouts_and_hold();
        test_random_traffic();
        wait_drained(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("tb_peer_freshness_table: done, clean");
        else
            $display("tb_peer_freshness_table: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pft_pkg.sv
rtl/core/pft_alu.sv
rtl/core/pft_store.sv
rtl/core/peer_freshness_table.sv
bench/tb_peer_freshness_table.sv
